// ===== hdl/sbae_pkg.sv =====
// ----------------------------------------------------------------------------
// sbae_pkg
// Shared types and opcode codes for the stack/branch/ALU execute unit.
// ----------------------------------------------------------------------------
package sbae_pkg;

   // short unconditional jumps, displacement 2..8
   localparam logic [6:0] K_J2    = 7'd1;
   localparam logic [6:0] K_J3    = 7'd2;
   localparam logic [6:0] K_J4    = 7'd3;
   localparam logic [6:0] K_J5    = 7'd4;
   localparam logic [6:0] K_J6    = 7'd5;
   localparam logic [6:0] K_J7    = 7'd6;
   localparam logic [6:0] K_J8    = 7'd7;
   localparam logic [6:0] K_JB    = 7'd8;
   localparam logic [6:0] K_JW    = 7'd9;
   localparam logic [6:0] K_JEP   = 7'd10;
   localparam logic [6:0] K_JEB   = 7'd12;
   localparam logic [6:0] K_JNEP  = 7'd13;
   localparam logic [6:0] K_JNEB  = 7'd15;
   localparam logic [6:0] K_JE    = 7'd11;
   localparam logic [6:0] K_JNE   = 7'd14;
   localparam logic [6:0] K_JL    = 7'd16;
   localparam logic [6:0] K_JGE   = 7'd17;
   localparam logic [6:0] K_JG    = 7'd18;
   localparam logic [6:0] K_JLE   = 7'd19;
   localparam logic [6:0] K_JUL   = 7'd20;
   localparam logic [6:0] K_JUGE  = 7'd21;
   localparam logic [6:0] K_JUG   = 7'd22;
   localparam logic [6:0] K_JULE  = 7'd23;
   localparam logic [6:0] K_JZ3   = 7'd24;
   localparam logic [6:0] K_JZ4   = 7'd25;
   localparam logic [6:0] K_JZB   = 7'd26;
   localparam logic [6:0] K_JNZ3  = 7'd27;
   localparam logic [6:0] K_JNZ4  = 7'd28;
   localparam logic [6:0] K_JNZB  = 7'd29;
   localparam logic [6:0] K_JDE   = 7'd30;
   localparam logic [6:0] K_JDNE  = 7'd31;
   localparam logic [6:0] K_REC   = 7'd34;
   localparam logic [6:0] K_REC2  = 7'd35;
   localparam logic [6:0] K_DIS   = 7'd36;
   localparam logic [6:0] K_DIS2  = 7'd37;
   localparam logic [6:0] K_EXCH  = 7'd38;
   localparam logic [6:0] K_DEXCH = 7'd39;
   localparam logic [6:0] K_DUP   = 7'd40;
   localparam logic [6:0] K_DDUP  = 7'd41;
   localparam logic [6:0] K_EXDIS = 7'd42;
   localparam logic [6:0] K_NEG   = 7'd43;
   localparam logic [6:0] K_INC   = 7'd44;
   localparam logic [6:0] K_DEC   = 7'd45;
   localparam logic [6:0] K_DINC  = 7'd46;
   localparam logic [6:0] K_DBL   = 7'd47;
   localparam logic [6:0] K_DDBL  = 7'd48;
   localparam logic [6:0] K_TRPL  = 7'd49;
   localparam logic [6:0] K_AND   = 7'd50;
   localparam logic [6:0] K_IOR   = 7'd51;
   localparam logic [6:0] K_ADDSB = 7'd52;
   localparam logic [6:0] K_ADD   = 7'd53;
   localparam logic [6:0] K_SUB   = 7'd54;
   localparam logic [6:0] K_DADD  = 7'd55;
   localparam logic [6:0] K_DSUB  = 7'd56;
   localparam logic [6:0] K_ADC   = 7'd57;
   localparam logic [6:0] K_ACD   = 7'd58;
   localparam logic [6:0] K_MUL   = 7'd60;
   localparam logic [6:0] K_DCMP  = 7'd61;
   localparam logic [6:0] K_UDCMP = 7'd62;
   localparam logic [6:0] K_PUSH  = 7'd64;

   typedef struct packed {
      logic [6:0]  kind;
      logic [7:0]  alpha;
      logic [7:0]  beta;
      logic [15:0] saved_pc;
      logic [15:0] push_value;
   } req_type;

   typedef struct packed {
      logic        branch_taken;
      logic [15:0] target_pc;
      logic        stk_fault;
      logic [15:0] top_word;
      logic [15:0] next_word;
      logic [3:0]  depth;
   } rsp_type;

endpackage

// ===== hdl/stack_branch_alu_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_branch_alu_execute_unit
// Executes one jump, stack or ALU instruction per transfer on a register stack.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction (kind, code bytes, pc, push word). Each
//   accepted transfer is executed in the cycle it is accepted: the evaluation
//   stack (STACK_DEPTH flip-flop words) is updated at that edge and the result
//   transfer is registered, so rsp_valid rises the next cycle.
//   Throughput is one instruction per cycle while req_ready is high; the single
//   combinational pass reads up to four top words, one 16x16 multiplier and a 32-bit adder.
//   req_ready is high whenever the result register is empty or is being
//   drained in the same cycle, so a stalled receiver holds at most one result
//   and back-pressure reaches the sender only after that.
//   Reset clears the stack pointer, all stack words and the result valid.
//   A fault (underflow/overflow) reports stk_fault and leaves the stack as is.
// ----------------------------------------------------------------------------
module stack_branch_alu_execute_unit #(
   parameter int STACK_DEPTH = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sbae_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbae_pkg::rsp_type rsp_data
);

   localparam int PW = $clog2(STACK_DEPTH + 1);  // pointer width
   localparam int IW = $clog2(STACK_DEPTH);      // index width

   localparam logic [PW:0] ONE   = (PW+1)'(1);
   localparam logic [PW:0] TWO   = (PW+1)'(2);
   localparam logic [PW:0] THREE = (PW+1)'(3);
   localparam logic [PW:0] FOUR  = (PW+1)'(4);

   logic [15:0]   stk_ff [STACK_DEPTH];
   logic [15:0]   stk_in [STACK_DEPTH];
   logic [PW-1:0] sp_ff, sp_in;
   logic          vld_ff;
   sbae_pkg::rsp_type rsp_ff, rsp_in;
   logic          go;

   assign req_ready = !vld_ff || rsp_ready;
   assign go        = req_valid && req_ready;
   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

   // word at pointer offset -n (n=1 top); zero if out of range
   function automatic logic [15:0] rd(input logic [15:0] s [STACK_DEPTH],
                                      input logic [PW-1:0] p, input int n);
      logic [PW:0] i;
      i = {1'b0, p} - (PW+1)'(n);
      rd = (i[PW] || i >= (PW+1)'(STACK_DEPTH)) ? 16'h0 : s[i[IW-1:0]];
   endfunction

   always_comb begin
      logic [6:0]  k;
      logic [PW:0] p, rdn, wrn, np;
      logic        err, tk, fit;
      logic [15:0] w1, w2, w3, w4, disp, sxa, sxb, r16;
      logic [31:0] lo, hi, r32;
      logic [1:0]  wmode;  // 0 none, 1 word, 2 dword, 3 double exchange
      logic [PW:0] wat;
      k = req_data.kind;
      p = {1'b0, sp_ff};
      w1 = rd(stk_ff, sp_ff, 1);
      w2 = rd(stk_ff, sp_ff, 2);
      w3 = rd(stk_ff, sp_ff, 3);
      w4 = rd(stk_ff, sp_ff, 4);
      lo = {w3, w4};
      hi = {w1, w2};
      sxa = {{8{req_data.alpha[7]}}, req_data.alpha};
      sxb = {{8{req_data.beta[7]}}, req_data.beta};
      rdn = '0; wrn = '0; np = p; tk = 1'b0; disp = 16'h0;
      wmode = 2'd0; wat = '0; r16 = 16'h0; r32 = 32'h0;
      case (k)
         sbae_pkg::K_J2, sbae_pkg::K_J3, sbae_pkg::K_J4, sbae_pkg::K_J5,
         sbae_pkg::K_J6, sbae_pkg::K_J7, sbae_pkg::K_J8: begin
            tk = 1'b1; disp = {9'h0, k} + 16'd1;
         end
         sbae_pkg::K_JB: begin tk = 1'b1; disp = sxa; end
         sbae_pkg::K_JW: begin tk = 1'b1; disp = {req_data.alpha, req_data.beta}; end
         sbae_pkg::K_JEP, sbae_pkg::K_JNEP: begin
            rdn = ONE; np = p - ONE; disp = {12'h0, req_data.alpha[3:0]} + 16'd4;
            tk = (w1 == {12'h0, req_data.alpha[7:4]}) != (k == sbae_pkg::K_JNEP);
         end
         sbae_pkg::K_JEB, sbae_pkg::K_JNEB: begin
            rdn = ONE; np = p - ONE; disp = sxb;
            tk = (w1 == {8'h0, req_data.alpha}) != (k == sbae_pkg::K_JNEB);
         end
         sbae_pkg::K_JE, sbae_pkg::K_JNE, sbae_pkg::K_JL, sbae_pkg::K_JGE,
         sbae_pkg::K_JG, sbae_pkg::K_JLE, sbae_pkg::K_JUL, sbae_pkg::K_JUGE,
         sbae_pkg::K_JUG, sbae_pkg::K_JULE: begin
            rdn = TWO; np = p - TWO; disp = sxa;
            case (k)
               sbae_pkg::K_JE:   tk = w2 == w1;
               sbae_pkg::K_JNE:  tk = w2 != w1;
               sbae_pkg::K_JL:   tk = $signed(w2) <  $signed(w1);
               sbae_pkg::K_JGE:  tk = $signed(w2) >= $signed(w1);
               sbae_pkg::K_JG:   tk = $signed(w2) >  $signed(w1);
               sbae_pkg::K_JLE:  tk = $signed(w2) <= $signed(w1);
               sbae_pkg::K_JUL:  tk = w2 <  w1;
               sbae_pkg::K_JUGE: tk = w2 >= w1;
               sbae_pkg::K_JUG:  tk = w2 >  w1;
               default:          tk = w2 <= w1;
            endcase
         end
         sbae_pkg::K_JZ3, sbae_pkg::K_JZ4, sbae_pkg::K_JZB,
         sbae_pkg::K_JNZ3, sbae_pkg::K_JNZ4, sbae_pkg::K_JNZB: begin
            rdn = ONE; np = p - ONE;
            tk = (w1 == 16'h0) != (k >= sbae_pkg::K_JNZ3);
            disp = (k == sbae_pkg::K_JZ3 || k == sbae_pkg::K_JNZ3) ? 16'd3 :
                   (k == sbae_pkg::K_JZ4 || k == sbae_pkg::K_JNZ4) ? 16'd4 : sxa;
         end
         sbae_pkg::K_JDE, sbae_pkg::K_JDNE: begin
            rdn = FOUR; np = p - FOUR; disp = sxa;
            tk = (lo == hi) != (k == sbae_pkg::K_JDNE);
         end
         sbae_pkg::K_REC:  begin wrn = ONE; np = p + ONE; end
         sbae_pkg::K_REC2: begin wrn = TWO; np = p + TWO; end
         sbae_pkg::K_DIS:  begin rdn = ONE; np = p - ONE; end
         sbae_pkg::K_DIS2: begin rdn = TWO; np = p - TWO; end
         sbae_pkg::K_EXCH: begin
            rdn = TWO; wrn = TWO; wmode = 2'd2; wat = p - TWO; r32 = {w2, w1};
         end
         sbae_pkg::K_DEXCH: begin
            rdn = FOUR; wrn = FOUR; wmode = 2'd3; wat = p - FOUR;
         end
         sbae_pkg::K_DUP: begin
            rdn = ONE; wrn = TWO; wmode = 2'd1; wat = p; r16 = w1; np = p + ONE;
         end
         sbae_pkg::K_DDUP: begin
            rdn = TWO; wrn = FOUR; wmode = 2'd2; wat = p; r32 = {w1, w2}; np = p + TWO;
         end
         sbae_pkg::K_EXDIS: begin
            rdn = TWO; wrn = ONE; wmode = 2'd1; wat = p - TWO; r16 = w1; np = p - ONE;
         end
         sbae_pkg::K_NEG, sbae_pkg::K_INC, sbae_pkg::K_DEC, sbae_pkg::K_DBL,
         sbae_pkg::K_TRPL, sbae_pkg::K_ADDSB: begin
            rdn = ONE; wrn = ONE; wmode = 2'd1; wat = p - ONE;
            case (k)
               sbae_pkg::K_NEG:  r16 = 16'h0 - w1;
               sbae_pkg::K_INC:  r16 = w1 + 16'd1;
               sbae_pkg::K_DEC:  r16 = w1 - 16'd1;
               sbae_pkg::K_DBL:  r16 = {w1[14:0], 1'b0};
               sbae_pkg::K_TRPL: r16 = {w1[14:0], 1'b0} + w1;
               default:          r16 = w1 + sxa;
            endcase
         end
         sbae_pkg::K_DINC, sbae_pkg::K_DDBL: begin
            rdn = TWO; wrn = TWO; wmode = 2'd2; wat = p - TWO;
            r32 = (k == sbae_pkg::K_DINC) ? hi + 32'd1 : {hi[30:0], 1'b0};
         end
         sbae_pkg::K_AND, sbae_pkg::K_IOR, sbae_pkg::K_ADD, sbae_pkg::K_SUB: begin
            rdn = TWO; wrn = ONE; wmode = 2'd1; wat = p - TWO; np = p - ONE;
            case (k)
               sbae_pkg::K_AND: r16 = w2 & w1;
               sbae_pkg::K_IOR: r16 = w2 | w1;
               sbae_pkg::K_ADD: r16 = w2 + w1;
               default:         r16 = w2 - w1;
            endcase
         end
         sbae_pkg::K_DADD, sbae_pkg::K_DSUB: begin
            rdn = FOUR; wrn = TWO; wmode = 2'd2; wat = p - FOUR; np = p - TWO;
            r32 = (k == sbae_pkg::K_DADD) ? lo + hi : lo - hi;
         end
         sbae_pkg::K_ADC: begin
            rdn = THREE; wrn = TWO; wmode = 2'd2; wat = p - THREE; np = p - ONE;
            r32 = {w2, w3} + {16'h0, w1};
         end
         sbae_pkg::K_ACD: begin
            rdn = THREE; wrn = TWO; wmode = 2'd2; wat = p - THREE; np = p - ONE;
            r32 = {w1, w2} + {16'h0, w3};
         end
         sbae_pkg::K_MUL: begin
            rdn = TWO; wrn = TWO; wmode = 2'd2; wat = p - TWO; np = p - ONE;
            r32 = {16'h0, w2} * {16'h0, w1};
         end
         sbae_pkg::K_DCMP, sbae_pkg::K_UDCMP: begin
            rdn = FOUR; wrn = ONE; wmode = 2'd1; wat = p - FOUR; np = p - THREE;
            if (lo == hi) r16 = 16'h0;
            else if (k == sbae_pkg::K_DCMP)
               r16 = ($signed(lo) > $signed(hi)) ? 16'd1 : 16'hFFFF;
            else r16 = (lo > hi) ? 16'd1 : 16'hFFFF;
         end
         sbae_pkg::K_PUSH: begin
            wrn = ONE; wmode = 2'd1; wat = p; r16 = req_data.push_value; np = p + ONE;
         end
         default: ;
      endcase
      fit = (p >= rdn) && ((p - rdn + wrn) <= (PW+1)'(STACK_DEPTH));
      err = !fit;
      if (err) begin
         tk = 1'b0; np = p; wmode = 2'd0;
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
         stk_in[i] = stk_ff[i];
         if (wmode == 2'd1 && wat == (PW+1)'(i)) stk_in[i] = r16;
         if (wmode == 2'd2 && wat == (PW+1)'(i)) stk_in[i] = r32[15:0];
         if (wmode == 2'd2 && wat + ONE == (PW+1)'(i)) stk_in[i] = r32[31:16];
         // double exchange: swap the two low/high pairs
         if (wmode == 2'd3 && wat == (PW+1)'(i)) stk_in[i] = w2;
         if (wmode == 2'd3 && wat + ONE == (PW+1)'(i)) stk_in[i] = w1;
         if (wmode == 2'd3 && wat + TWO == (PW+1)'(i)) stk_in[i] = w4;
         if (wmode == 2'd3 && wat + THREE == (PW+1)'(i)) stk_in[i] = w3;
      end
      sp_in = np[PW-1:0];
      rsp_in.branch_taken = tk;
      rsp_in.target_pc    = tk ? req_data.saved_pc + disp : 16'h0;
      rsp_in.stk_fault    = err;
      rsp_in.top_word     = rd(stk_in, sp_in, 1);
      rsp_in.next_word    = rd(stk_in, sp_in, 2);
      rsp_in.depth        = 4'(np);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         vld_ff <= 1'b0;
         for (int i = 0; i < STACK_DEPTH; i++) stk_ff[i] <= 16'h0;
      end else begin
         if (go) begin
            sp_ff  <= sp_in;
            stk_ff <= stk_in;
            rsp_ff <= rsp_in;
            vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

endmodule
